// File: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL; clock is clk, reset is rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/rgbspec_pkg.sv
package rgbspec_pkg;

  localparam int RGB_W         = 16;
  localparam int WEIGHT_W      = 16;
  localparam int SAMPLE_IDX_W  = 6;
  localparam int POWER_W       = 17;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 17;
  localparam int START_W       = 17;
  localparam int STEP_W        = 14;
  localparam int COUNT_W       = 7;

  // Grid wavelength: start + 63 * step at full scale stays below 2^21.
  localparam int LAM_W         = 21;
  localparam int CTRL_W        = 17;
  localparam int CONTROL_POINTS = 10;
  localparam int SEG_W         = 4;
  localparam int SEG_LEN_W     = 12;
  localparam int BASIS_W       = 15;
  localparam int BASIS_SEL_W   = 3;
  localparam int PAIR_W        = 3;
  localparam int LANES         = 3;
  localparam int PROD_W        = 27;
  localparam int NUM_W         = 26;
  localparam int RECIP_SHIFT   = 27;
  localparam int RECIP_W       = 16;
  localparam int RECIP_PROD_W  = NUM_W + RECIP_W;
  localparam int TERM_W        = WEIGHT_W + BASIS_W;
  localparam int ACC_W         = TERM_W + 2;
  localparam int FRAC_BITS     = 14;
  localparam int SHIFTED_W     = ACC_W - FRAC_BITS;

  localparam logic [ACC_W-1:0]   ROUND_HALF = ACC_W'(1 << (FRAC_BITS - 1));
  localparam logic [POWER_W-1:0] POWER_MAX  = {POWER_W{1'b1}};

  localparam logic [CFG_INDEX_W-1:0] CFG_LAMBDA_START = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LAMBDA_STEP  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_COUNT = 2'd2;

  localparam logic [START_W-1:0] LAMBDA_START_RST = 17'd38000;
  localparam logic [STEP_W-1:0]  LAMBDA_STEP_RST  = 14'd1000;
  localparam logic [COUNT_W-1:0] SAMPLE_COUNT_RST = 7'd35;

  // Basis codes.
  localparam logic [BASIS_SEL_W-1:0] BASIS_WHITE   = 3'd0;
  localparam logic [BASIS_SEL_W-1:0] BASIS_CYAN    = 3'd1;
  localparam logic [BASIS_SEL_W-1:0] BASIS_MAGENTA = 3'd2;
  localparam logic [BASIS_SEL_W-1:0] BASIS_YELLOW  = 3'd3;
  localparam logic [BASIS_SEL_W-1:0] BASIS_RED     = 3'd4;
  localparam logic [BASIS_SEL_W-1:0] BASIS_GREEN   = 3'd5;
  localparam logic [BASIS_SEL_W-1:0] BASIS_BLUE    = 3'd6;

  // Basis pair codes.
  localparam logic [PAIR_W-1:0] PAIR_CYAN_BLUE     = 3'd0;
  localparam logic [PAIR_W-1:0] PAIR_CYAN_GREEN    = 3'd1;
  localparam logic [PAIR_W-1:0] PAIR_MAGENTA_BLUE  = 3'd2;
  localparam logic [PAIR_W-1:0] PAIR_MAGENTA_RED   = 3'd3;
  localparam logic [PAIR_W-1:0] PAIR_YELLOW_GREEN  = 3'd4;
  localparam logic [PAIR_W-1:0] PAIR_YELLOW_RED    = 3'd5;

  localparam logic [BASIS_SEL_W-1:0] PAIR_FIRST [0:7] = '{
    BASIS_CYAN, BASIS_CYAN, BASIS_MAGENTA, BASIS_MAGENTA,
    BASIS_YELLOW, BASIS_YELLOW, BASIS_CYAN, BASIS_CYAN};
  localparam logic [BASIS_SEL_W-1:0] PAIR_SECOND [0:7] = '{
    BASIS_BLUE, BASIS_GREEN, BASIS_BLUE, BASIS_RED,
    BASIS_GREEN, BASIS_RED, BASIS_BLUE, BASIS_BLUE};

  localparam logic [CTRL_W-1:0] CTRL_LAMBDA [0:CONTROL_POINTS-1] = '{
    17'd38000, 17'd41770, 17'd45555, 17'd49333, 17'd53111,
    17'd56888, 17'd60666, 17'd64444, 17'd68222, 17'd72000};

  // Segment k spans control points k-1 .. k; entry 0 is unused.
  localparam logic [SEG_LEN_W-1:0] SEG_LEN [0:CONTROL_POINTS-1] = '{
    12'd0,
    SEG_LEN_W'(CTRL_LAMBDA[1] - CTRL_LAMBDA[0]),
    SEG_LEN_W'(CTRL_LAMBDA[2] - CTRL_LAMBDA[1]),
    SEG_LEN_W'(CTRL_LAMBDA[3] - CTRL_LAMBDA[2]),
    SEG_LEN_W'(CTRL_LAMBDA[4] - CTRL_LAMBDA[3]),
    SEG_LEN_W'(CTRL_LAMBDA[5] - CTRL_LAMBDA[4]),
    SEG_LEN_W'(CTRL_LAMBDA[6] - CTRL_LAMBDA[5]),
    SEG_LEN_W'(CTRL_LAMBDA[7] - CTRL_LAMBDA[6]),
    SEG_LEN_W'(CTRL_LAMBDA[8] - CTRL_LAMBDA[7]),
    SEG_LEN_W'(CTRL_LAMBDA[9] - CTRL_LAMBDA[8])};

  // floor(2^RECIP_SHIFT / segment length); quotient estimate is low by at most one.
  localparam logic [RECIP_W-1:0] SEG_RECIP [0:CONTROL_POINTS-1] = '{
    16'd0,
    RECIP_W'((64'd1 << RECIP_SHIFT) / (CTRL_LAMBDA[1] - CTRL_LAMBDA[0])),
    RECIP_W'((64'd1 << RECIP_SHIFT) / (CTRL_LAMBDA[2] - CTRL_LAMBDA[1])),
    RECIP_W'((64'd1 << RECIP_SHIFT) / (CTRL_LAMBDA[3] - CTRL_LAMBDA[2])),
    RECIP_W'((64'd1 << RECIP_SHIFT) / (CTRL_LAMBDA[4] - CTRL_LAMBDA[3])),
    RECIP_W'((64'd1 << RECIP_SHIFT) / (CTRL_LAMBDA[5] - CTRL_LAMBDA[4])),
    RECIP_W'((64'd1 << RECIP_SHIFT) / (CTRL_LAMBDA[6] - CTRL_LAMBDA[5])),
    RECIP_W'((64'd1 << RECIP_SHIFT) / (CTRL_LAMBDA[7] - CTRL_LAMBDA[6])),
    RECIP_W'((64'd1 << RECIP_SHIFT) / (CTRL_LAMBDA[8] - CTRL_LAMBDA[7])),
    RECIP_W'((64'd1 << RECIP_SHIFT) / (CTRL_LAMBDA[9] - CTRL_LAMBDA[8]))};

  // Q1.14 basis control values: white, cyan, magenta, yellow, red, green, blue.
  localparam logic [BASIS_W-1:0] BASIS_TAB [0:6][0:CONTROL_POINTS-1] = '{
    '{15'd16384, 15'd16384, 15'd16382, 15'd16373, 15'd16371,
      15'd16381, 15'd16384, 15'd16384, 15'd16384, 15'd16384},
    '{15'd15909, 15'd15444, 15'd16395, 15'd16395, 15'd16395,
      15'd16395, 15'd2562,  15'd0,     15'd0,     15'd0},
    '{15'd16384, 15'd16384, 15'd15868, 15'd3652,  15'd0,
      15'd750,   15'd13712, 15'd16384, 15'd16384, 15'd16317},
    '{15'd2,     15'd0,     15'd1783,  15'd10897, 15'd16384,
      15'd16384, 15'd16377, 15'd15706, 15'd15868, 15'd16122},
    '{15'd1658,  15'd844,   15'd0,     15'd0,     15'd0,
      15'd0,     15'd13640, 15'd16628, 15'd16628, 15'd16628},
    '{15'd0,     15'd0,     15'd447,   15'd13004, 15'd16384,
      15'd15430, 15'd2816,  15'd0,     15'd0,     15'd41},
    '{15'd16384, 15'd16384, 15'd14608, 15'd5444,  15'd0,
      15'd0,     15'd5,     15'd605,   15'd791,   15'd813}};

  typedef struct packed {
    logic [RGB_W-1:0] red;
    logic [RGB_W-1:0] green;
    logic [RGB_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [SAMPLE_IDX_W-1:0] sample_index;
    logic [POWER_W-1:0]      power;
    logic                    last;
  } sample_t;

endpackage

// File: hw/rtl/rgb_to_spectrum_generator.sv
// Channel  Direction  Payload                         Handshake
// in       input      rgb_t (red, green, blue Q2.14)  in_valid / in_ready
// out      output     sample_t (index, power, last)   out_valid / out_ready
// cfg      input      cfg_index, cfg_data             cfg_valid / cfg_ready
//
// One spectral sample leaves per cycle unless out_ready holds the output; a colour holds
// the sample sequencer to load the weights and then for n samples (n = sample_count
// clamped to MAX_SAMPLES). Samples reach out_valid through the interpolation pipeline.
// Reset is synchronous on rst_n and restores the register defaults; no clearing pass.
// A held result at the output freezes every pipeline stage and the grid walk together;
// an idle sequencer still takes the next colour during the stall.
`include "assert_macros.svh"

module rgb_to_spectrum_generator
  import rgbspec_pkg::*;
#(
  parameter int MAX_SAMPLES = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  rgb_t                   in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output sample_t                out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int IDX_W = $clog2(MAX_SAMPLES);
  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int LAST_STAGE = 7;

  typedef enum logic {ST_IDLE, ST_RUN} seq_state_t;

  typedef struct packed {
    logic [IDX_W-1:0]    idx;
    logic                last;
    logic [WEIGHT_W-1:0] ww;
    logic [WEIGHT_W-1:0] w1;
    logic [WEIGHT_W-1:0] w2;
    logic [PAIR_W-1:0]   pair;
  } ctl_t;

  // Configuration
  logic [START_W-1:0] lambda_start_r;
  logic [STEP_W-1:0]  lambda_step_r;
  logic [COUNT_W-1:0] sample_count_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lambda_start_r <= LAMBDA_START_RST;
      lambda_step_r  <= LAMBDA_STEP_RST;
      sample_count_r <= SAMPLE_COUNT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_LAMBDA_START: lambda_start_r <= cfg_data[START_W-1:0];
        CFG_LAMBDA_STEP:  lambda_step_r  <= cfg_data[STEP_W-1:0];
        CFG_SAMPLE_COUNT: sample_count_r <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline advances whenever the output register is free or being drained
  logic             out_valid_r;
  sample_t          out_data_r;
  logic             adv;
  logic [LAST_STAGE:1] v_r;

  assign adv = !out_valid_r || out_ready;

  // Sequencer: split the colour into weights, then walk the grid
  seq_state_t         state_r;
  logic [LAM_W-1:0]   lam_r;
  logic [IDX_W-1:0]   idx_r;
  logic [CNT_W-1:0]   n_r;
  logic [WEIGHT_W-1:0] ww_r, w1_r, w2_r;
  logic [PAIR_W-1:0]  pair_r;

  logic [WEIGHT_W-1:0] ww_nxt, w1_nxt, w2_nxt;
  logic [PAIR_W-1:0]   pair_nxt;
  logic [CNT_W-1:0]    n_nxt;
  logic                in_acc;
  logic                issue;
  logic                seq_last;
  logic                seq_hold;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign issue    = (state_r == ST_RUN) && adv;
  assign seq_last = (idx_r == IDX_W'(n_r - 1'b1));
  assign seq_hold = !adv && !in_acc;

  always_comb begin
    logic [RGB_W-1:0] r, g, b;
    r = in_data.red;
    g = in_data.green;
    b = in_data.blue;
    if (r <= g && r <= b) begin
      ww_nxt = r;
      if (g <= b) begin
        pair_nxt = PAIR_CYAN_BLUE;
        w1_nxt   = g - r;
        w2_nxt   = b - g;
      end else begin
        pair_nxt = PAIR_CYAN_GREEN;
        w1_nxt   = b - r;
        w2_nxt   = g - b;
      end
    end else if (g <= r && g <= b) begin
      ww_nxt = g;
      if (r <= b) begin
        pair_nxt = PAIR_MAGENTA_BLUE;
        w1_nxt   = r - g;
        w2_nxt   = b - r;
      end else begin
        pair_nxt = PAIR_MAGENTA_RED;
        w1_nxt   = b - g;
        w2_nxt   = r - b;
      end
    end else begin
      ww_nxt = b;
      if (r <= g) begin
        pair_nxt = PAIR_YELLOW_GREEN;
        w1_nxt   = r - b;
        w2_nxt   = g - r;
      end else begin
        pair_nxt = PAIR_YELLOW_RED;
        w1_nxt   = g - b;
        w2_nxt   = r - g;
      end
    end
    n_nxt = (int'(sample_count_r) > MAX_SAMPLES) ? CNT_W'(MAX_SAMPLES)
                                                   : CNT_W'(sample_count_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      lam_r   <= '0;
      idx_r   <= '0;
      n_r     <= '0;
      ww_r    <= '0;
      w1_r    <= '0;
      w2_r    <= '0;
      pair_r  <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            ww_r    <= ww_nxt;
            w1_r    <= w1_nxt;
            w2_r    <= w2_nxt;
            pair_r  <= pair_nxt;
            n_r     <= n_nxt;
            lam_r   <= LAM_W'(lambda_start_r);
            idx_r   <= '0;
            // an empty run loads the weights and emits nothing
            if (n_nxt != '0) begin
              state_r <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (adv) begin
            lam_r <= lam_r + LAM_W'(lambda_step_r);
            idx_r <= idx_r + 1'b1;
            if (seq_last) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Valid bits travel with the stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v_r         <= {v_r[LAST_STAGE-1:1], issue};
      out_valid_r <= v_r[LAST_STAGE];
    end
  end

  ctl_t ctl_r [1:LAST_STAGE];

  // Stage 1: locate the segment around the grid wavelength
  logic                 s1_inr_r;
  logic [SEG_W-1:0]     s1_seg_r;
  logic [SEG_LEN_W-1:0] s1_dl_r, s1_dh_r;

  logic                 s1_inr;
  logic [SEG_W-1:0]     s1_seg;
  logic [LAM_W-1:0]     s1_dl_full, s1_dh_full;

  always_comb begin
    s1_inr = (lam_r >= LAM_W'(CTRL_LAMBDA[0])) &&
             (lam_r <= LAM_W'(CTRL_LAMBDA[CONTROL_POINTS-1]));
    s1_seg = SEG_W'(CONTROL_POINTS - 1);
    for (int k = CONTROL_POINTS - 2; k >= 1; k--) begin
      if (LAM_W'(CTRL_LAMBDA[k]) >= lam_r) begin
        s1_seg = SEG_W'(k);
      end
    end
    s1_dl_full = lam_r - LAM_W'(CTRL_LAMBDA[s1_seg - 1'b1]);
    s1_dh_full = LAM_W'(CTRL_LAMBDA[s1_seg]) - lam_r;
  end

  // Stage 2: weighted control values
  logic                 s2_inr_r;
  logic [SEG_W-1:0]     s2_seg_r;
  logic [PROD_W-1:0]    s2_plo_r [0:LANES-1];
  logic [PROD_W-1:0]    s2_phi_r [0:LANES-1];
  logic [BASIS_SEL_W-1:0] s2_bsel [0:LANES-1];

  always_comb begin
    s2_bsel[0] = BASIS_WHITE;
    s2_bsel[1] = PAIR_FIRST[ctl_r[1].pair];
    s2_bsel[2] = PAIR_SECOND[ctl_r[1].pair];
  end

  // Stage 3: numerator with half-segment rounding
  logic                 s3_inr_r;
  logic [SEG_W-1:0]     s3_seg_r;
  logic [NUM_W-1:0]     s3_x_r [0:LANES-1];

  // Stage 4: quotient estimate by reciprocal
  logic                 s4_inr_r;
  logic [SEG_W-1:0]     s4_seg_r;
  logic [NUM_W-1:0]     s4_x_r [0:LANES-1];
  logic [BASIS_W-1:0]   s4_q_r [0:LANES-1];

  // Stage 5: back-multiply the estimate
  logic                 s5_inr_r;
  logic [SEG_W-1:0]     s5_seg_r;
  logic [NUM_W-1:0]     s5_x_r  [0:LANES-1];
  logic [BASIS_W-1:0]   s5_q_r  [0:LANES-1];
  logic [PROD_W-1:0]    s5_qd_r [0:LANES-1];

  // Stage 6: correct by one and mask outside the control wavelength range
  logic [BASIS_W-1:0]   s6_b_r [0:LANES-1];
  logic [NUM_W-1:0]     s5_rem [0:LANES-1];
  logic [LANES-1:0]     s5_rem_ok;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      s5_rem[l]    = s5_x_r[l] - NUM_W'(s5_qd_r[l]);
      s5_rem_ok[l] = (s5_rem[l] < NUM_W'(2 * SEG_LEN[s5_seg_r]));
    end
  end

  // Stage 7: weight times basis value
  logic [TERM_W-1:0]    s7_p_r [0:LANES-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl_r[1] <= '{idx: idx_r, last: seq_last, ww: ww_r, w1: w1_r, w2: w2_r,
                    pair: pair_r};
      for (int s = 2; s <= LAST_STAGE; s++) begin
        ctl_r[s] <= ctl_r[s-1];
      end

      s1_inr_r <= s1_inr;
      s1_seg_r <= s1_seg;
      s1_dl_r  <= s1_dl_full[SEG_LEN_W-1:0];
      s1_dh_r  <= s1_dh_full[SEG_LEN_W-1:0];

      s2_inr_r <= s1_inr_r;
      s2_seg_r <= s1_seg_r;
      for (int l = 0; l < LANES; l++) begin
        s2_plo_r[l] <= PROD_W'(BASIS_TAB[s2_bsel[l]][s1_seg_r - 1'b1]) * PROD_W'(s1_dh_r);
        s2_phi_r[l] <= PROD_W'(BASIS_TAB[s2_bsel[l]][s1_seg_r]) * PROD_W'(s1_dl_r);
      end

      s3_inr_r <= s2_inr_r;
      s3_seg_r <= s2_seg_r;
      for (int l = 0; l < LANES; l++) begin
        s3_x_r[l] <= NUM_W'(s2_plo_r[l] + s2_phi_r[l] +
                            PROD_W'(SEG_LEN[s2_seg_r] >> 1));
      end

      s4_inr_r <= s3_inr_r;
      s4_seg_r <= s3_seg_r;
      for (int l = 0; l < LANES; l++) begin
        s4_x_r[l] <= s3_x_r[l];
        s4_q_r[l] <= BASIS_W'((RECIP_PROD_W'(s3_x_r[l]) *
                               RECIP_PROD_W'(SEG_RECIP[s3_seg_r])) >> RECIP_SHIFT);
      end

      s5_inr_r <= s4_inr_r;
      s5_seg_r <= s4_seg_r;
      for (int l = 0; l < LANES; l++) begin
        s5_x_r[l]  <= s4_x_r[l];
        s5_q_r[l]  <= s4_q_r[l];
        s5_qd_r[l] <= PROD_W'(s4_q_r[l]) * PROD_W'(SEG_LEN[s4_seg_r]);
      end

      for (int l = 0; l < LANES; l++) begin
        if (!s5_inr_r) begin
          s6_b_r[l] <= '0;
        end else if (s5_rem[l] >= NUM_W'(SEG_LEN[s5_seg_r])) begin
          s6_b_r[l] <= s5_q_r[l] + 1'b1;
        end else begin
          s6_b_r[l] <= s5_q_r[l];
        end
      end

      s7_p_r[0] <= TERM_W'(ctl_r[6].ww) * TERM_W'(s6_b_r[0]);
      s7_p_r[1] <= TERM_W'(ctl_r[6].w1) * TERM_W'(s6_b_r[1]);
      s7_p_r[2] <= TERM_W'(ctl_r[6].w2) * TERM_W'(s6_b_r[2]);
    end
  end

  // Output register: round, scale and saturate
  logic [ACC_W-1:0]     acc;
  logic [SHIFTED_W-1:0] acc_sh;
  logic [POWER_W-1:0]   power_nxt;

  always_comb begin
    acc    = ACC_W'(s7_p_r[0]) + ACC_W'(s7_p_r[1]) + ACC_W'(s7_p_r[2]) + ROUND_HALF;
    acc_sh = acc[ACC_W-1:FRAC_BITS];
    power_nxt = (acc_sh > SHIFTED_W'(POWER_MAX)) ? POWER_MAX : acc_sh[POWER_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r.sample_index <= SAMPLE_IDX_W'(ctl_r[LAST_STAGE].idx);
      out_data_r.power        <= power_nxt;
      out_data_r.last         <= ctl_r[LAST_STAGE].last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_NEXT(a_idle_no_issue, (state_r == ST_IDLE) && adv, !v_r[1], "sample issued while idle")
  `ASSERT_NEXT(a_stall_freezes, seq_hold, $stable({v_r, lam_r, idx_r}), "pipeline moved in stall")
  `ASSERT_NEXT(a_last_ends_run, issue && seq_last, state_r == ST_IDLE, "run did not end on last sample")
  `ASSERT_IMPLIES(a_recip_bound, v_r[5] && s5_inr_r, &s5_rem_ok, "reciprocal estimate too low")

endmodule
